>>> rtl/awrfd_pkg.sv
package awrfd_pkg;

    localparam int ACCEL_W = 13;
    localparam int MAG_W   = 26;
    localparam int THR_W   = 26;
    localparam int WL_W    = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = 26'd10000000;
    localparam logic [WL_W-1:0]  WINDOW_RESET    = 4'd2;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ_X,
        S_SQ_Y,
        S_SQ_Z,
        S_WRITE,
        S_READ,
        S_CMP,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } t_axis;

    typedef struct packed {
        logic  capture;
        logic  mac_en;
        t_axis axis;
        logic  store_wr;
        logic  rd_issue;
        logic  cmp_en;
        logic  scan_adv;
        logic  out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_dp_status;

endpackage

>>> rtl/awrfd_if.sv
interface awrfd_in_if;
    import awrfd_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [ACCEL_W-1:0] accel_x;
    logic signed [ACCEL_W-1:0] accel_y;
    logic signed [ACCEL_W-1:0] accel_z;

    modport source (output valid, accel_x, accel_y, accel_z, input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface awrfd_out_if;
    import awrfd_pkg::*;
    logic             valid;
    logic             ready;
    logic             fall_detected;
    logic [MAG_W-1:0] window_spread;
    logic [MAG_W-1:0] magnitude_squared;

    modport source (output valid, fall_detected, window_spread, magnitude_squared,
                    input ready);
    modport sink   (input valid, fall_detected, window_spread, magnitude_squared,
                    output ready);
endinterface

interface awrfd_cfg_if;
    import awrfd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [THR_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/awrfd_ctrl.sv
module awrfd_ctrl
    import awrfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.axis = AXIS_X;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_SQ_X;
                end
            end
            S_SQ_X: begin
                o_cmd.mac_en = 1'b1;
                o_cmd.axis   = AXIS_X;
                n_state      = S_SQ_Y;
            end
            S_SQ_Y: begin
                o_cmd.mac_en = 1'b1;
                o_cmd.axis   = AXIS_Y;
                n_state      = S_SQ_Z;
            end
            S_SQ_Z: begin
                o_cmd.mac_en = 1'b1;
                o_cmd.axis   = AXIS_Z;
                n_state      = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.store_wr = 1'b1;
                n_state        = S_READ;
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp_en = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.scan_adv = 1'b1;
                    n_state        = S_READ;
                end
            end
            S_DONE: begin
                // hold until the result register can take the new result
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/awrfd_dp.sv
module awrfd_dp
    import awrfd_pkg::*;
#(
    parameter int MAX_WINDOW = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    output t_dp_status                o_status,
    input  logic signed [ACCEL_W-1:0] i_accel_x,
    input  logic signed [ACCEL_W-1:0] i_accel_y,
    input  logic signed [ACCEL_W-1:0] i_accel_z,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [THR_W-1:0]          i_cfg_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_fall_detected,
    output logic [MAG_W-1:0]          o_window_spread,
    output logic [MAG_W-1:0]          o_magnitude_squared
);

    localparam int SW = $clog2(MAX_WINDOW);

    logic [THR_W-1:0]          r_threshold;
    logic [WL_W-1:0]           r_window_length;
    logic signed [ACCEL_W-1:0] r_x;
    logic signed [ACCEL_W-1:0] r_y;
    logic signed [ACCEL_W-1:0] r_z;
    logic [MAG_W-1:0]          r_acc;
    logic [MAG_W-1:0]          r_mem [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]     r_valid;
    logic [SW-1:0]             r_slot;
    logic [SW-1:0]             r_idx;
    logic [MAG_W-1:0]          r_rd_data;
    logic                      r_rd_valid;
    logic                      r_first;
    logic [MAG_W-1:0]          r_lo;
    logic [MAG_W-1:0]          r_hi;
    logic                      r_out_valid;
    logic                      r_fall;
    logic [MAG_W-1:0]          r_spread;
    logic [MAG_W-1:0]          r_mag;

    logic [WL_W-1:0]           w_eff;
    logic signed [ACCEL_W-1:0] sel_val;
    logic [ACCEL_W-1:0]        abs_val;
    logic [MAG_W-1:0]          square;
    logic [MAG_W-1:0]          entry;
    logic [MAG_W-1:0]          spread;
    logic                      slot_wrap;

    // zero means one; anything above the store depth saturates
    always_comb begin
        w_eff = r_window_length;
        if (r_window_length == '0) begin
            w_eff = WL_W'(1);
        end else if (int'(r_window_length) > MAX_WINDOW) begin
            w_eff = WL_W'(MAX_WINDOW);
        end
    end

    assign slot_wrap          = int'(r_slot) >= int'(w_eff) - 1;
    assign o_status.scan_last = int'(r_idx) >= int'(w_eff) - 1;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        case (i_cmd.axis)
            AXIS_X:  sel_val = r_x;
            AXIS_Y:  sel_val = r_y;
            AXIS_Z:  sel_val = r_z;
            default: sel_val = r_x;
        endcase
        // the most negative sample gives 4096, which still fits unsigned
        abs_val = sel_val[ACCEL_W-1] ? ACCEL_W'(-sel_val) : ACCEL_W'(sel_val);
        square  = MAG_W'(abs_val) * MAG_W'(abs_val);
    end

    assign entry  = r_rd_valid ? r_rd_data : '0;
    assign spread = r_hi - r_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold     <= THRESHOLD_RESET;
            r_window_length <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_THRESHOLD: r_threshold     <= i_cfg_data;
                REG_WINDOW:    r_window_length <= i_cfg_data[WL_W-1:0];
                default:       r_threshold     <= r_threshold;
            endcase
        end
    end

    // store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_wr) begin
            r_mem[r_slot] <= r_acc;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_slot     <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_cmd.store_wr) begin
                r_valid[r_slot] <= 1'b1;
                r_slot          <= slot_wrap ? '0 : r_slot + 1'b1;
            end
            if (i_cmd.rd_issue) begin
                r_rd_valid <= r_valid[r_idx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_x     <= i_accel_x;
            r_y     <= i_accel_y;
            r_z     <= i_accel_z;
            r_acc   <= '0;
            r_first <= 1'b1;
        end
        if (i_cmd.mac_en) begin
            r_acc <= r_acc + square;
        end
        if (i_cmd.store_wr) begin
            r_idx <= '0;
        end
        if (i_cmd.scan_adv) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.cmp_en) begin
            r_first <= 1'b0;
            if (r_first || entry < r_lo) begin
                r_lo <= entry;
            end
            if (r_first || entry > r_hi) begin
                r_hi <= entry;
            end
        end
        if (i_cmd.out_load) begin
            r_fall   <= spread > r_threshold;
            r_spread <= spread;
            r_mag    <= r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_fall_detected     = r_fall;
    assign o_window_spread     = r_spread;
    assign o_magnitude_squared = r_mag;

endmodule

>>> rtl/accel_window_range_fall_detector.sv
// Each sample is captured, squared axis by axis in the shared squarer (S_SQ_X, S_SQ_Y,
// S_SQ_Z) and written to the store; the min/max scan then reads each of the W entries
// through the single registered read port (S_READ, then S_CMP), W being the effective
// window length (1 to 8 at the default store depth). A new sample is taken only in S_IDLE.
// The result register lets the next sample in while a result waits.
// Synchronous active-low reset: store reads as zero, slot 0, threshold 10000000, window 2.
module accel_window_range_fall_detector
    import awrfd_pkg::*;
#(
    parameter int MAX_WINDOW = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    awrfd_in_if.sink           i_sample,
    awrfd_out_if.source        o_result,
    awrfd_cfg_if.sink          i_cfg
);

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       in_ready;

    assign i_sample.ready = in_ready;
    assign i_cfg.ready    = 1'b1;

    awrfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    awrfd_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_accel_x           (i_sample.accel_x),
        .i_accel_y           (i_sample.accel_y),
        .i_accel_z           (i_sample.accel_z),
        .i_cfg_we            (i_cfg.valid),
        .i_cfg_index         (i_cfg.index),
        .i_cfg_data          (i_cfg.data),
        .o_out_valid         (o_result.valid),
        .i_out_ready         (o_result.ready),
        .o_fall_detected     (o_result.fall_detected),
        .o_window_spread     (o_result.window_spread),
        .o_magnitude_squared (o_result.magnitude_squared)
    );

endmodule
